FILE: hdl/top_k_score_table_macros.svh
// assertion macros for the score table
`ifndef TOP_K_SCORE_TABLE_MACROS_SVH
`define TOP_K_SCORE_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

`define TKST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define TKST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define TKST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define TKST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/tkst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tkst_pkg;

	localparam int TKST_DEPTH_DEF = 8;
	localparam int DIN_W          = 40;
	localparam int DOUT_W         = 40;
	localparam int LETTER_W       = 5;
	localparam int TIME_W         = 10;
	localparam int SCORE_W        = 16;

	typedef struct packed {
		logic [LETTER_W-1:0] la;
		logic [LETTER_W-1:0] lb;
		logic [LETTER_W-1:0] lc;
		logic [TIME_W-1:0]   tm;
	} entry_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_ctl_t;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// x mod 26 by reciprocal estimate and one correction
	function automatic logic [LETTER_W-1:0] mod26(input logic [7:0] x);
		logic [15:0] p;
		logic [9:0]  qm;
		logic [7:0]  r;
		p  = 16'(x) * 16'd78;
		qm = 10'(p[15:11]) * 10'd26;
		r  = 8'(10'(x) - qm);
		if (r >= 8'd26) begin
			r = r - 8'd26;
		end
		return r[LETTER_W-1:0];
	endfunction

	// x mod 900 by reciprocal estimate and one correction
	function automatic logic [TIME_W-1:0] mod900(input logic [SCORE_W-1:0] x);
		logic [31:0] p;
		logic [16:0] qm;
		logic [15:0] r;
		p  = 32'(x) * 32'd1165;
		qm = 17'(p[26:20]) * 17'd900;
		r  = 16'(17'(x) - qm);
		if (r >= 16'd900) begin
			r = r - 16'd900;
		end
		return r[TIME_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/top_k_score_table.sv
`timescale 1ns / 1ps
`default_nettype none
//  channel   dir  handshake                tdata (low bit up)                 side
//  s_axis    in   s_axis_tvalid/tready     letter_a, letter_b, letter_c,      tuser: command
//                                          new_score
//  m_axis    out  m_axis_tvalid/tready     placed_slot, entry_index, letters, tlast: last
//                                          entry_time, entry_count
//
//  insert: one compare per slot in a single walk that reads slot i while writing
//  slot i-1 through the one-read one-write table memory; an empty table takes slot 0
//  read: memory read, then output load, for each entry in turn
//  reset clears the count, the state and the slot valid bits at once; no sweep
//  a stalled output holds emit and read walk; s_axis_tready is high only between items

`include "top_k_score_table_macros.svh"

module top_k_score_table
	import tkst_pkg::*;
#(
	parameter int TABLE_DEPTH = TKST_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// letter_a[7:0], letter_b[15:8], letter_c[23:16], new_score[39:24]
	input  wire logic [DIN_W-1:0]  s_axis_tdata,
	// command[0]
	input  wire logic              s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// placed_slot[3:0], entry_index[6:4], out_letter_a[11:7], out_letter_b[16:12],
	// out_letter_c[21:17], entry_time[31:22], entry_count[35:32], zero[39:36]
	output logic [DOUT_W-1:0]      m_axis_tdata,
	output logic                   m_axis_tlast
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_INS_SCAN = 5'b00010,
		ST_INS_EMIT = 5'b00100,
		ST_RD_REQ   = 5'b01000,
		ST_RD_OUT   = 5'b10000
	} state_t;

	state_t              st_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       placed_q;
	logic                found_q;
	logic [CW-1:0]       count_q;
	logic                ovld_q;

	logic [7:0]          la_q;
	logic [7:0]          lb_q;
	logic [7:0]          lc_q;
	logic [SCORE_W-1:0]  score_q;
	entry_t              carry_q;

	logic [3:0]          o_placed_q;
	logic [2:0]          o_idx_q;
	entry_t              o_entry_q;
	logic [3:0]          o_count_q;
	logic                o_last_q;

	mem_ctl_t            ctl;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;
	entry_t              rd_entry;
	entry_t              ne;
	logic [CW-1:0]       wslot;
	logic                hit;
	logic                accept;
	logic                out_free;
	logic                load;
	logic [CW-1:0]       count_nxt;

	tkst_store #(
		.DEPTH (TABLE_DEPTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_entry (rd_entry)
	);

	assign s_axis_tready = (st_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !ovld_q || m_axis_tready;
	assign load          = out_free && ((st_q == ST_INS_EMIT) || (st_q == ST_RD_OUT));
	assign count_nxt     = (found_q && (count_q != DEPTH_C)) ? count_q + CW'(1) : count_q;

	assign ne.la = mod26(la_q);
	assign ne.lb = mod26(lb_q);
	assign ne.lc = mod26(lc_q);
	assign ne.tm = mod900(score_q);

	// slot whose read data is back this cycle
	assign wslot = cnt_q - CW'(1);
	assign hit   = score_q > SCORE_W'(rd_entry.tm);

	always_comb begin
		ctl     = '0;
		rd_addr = cnt_q[AW-1:0];
		wr_addr = wslot[AW-1:0];
		wr_data = ne;
		unique case (st_q)
			ST_INS_SCAN: begin
				if (count_q == '0) begin
					ctl.clr = 1'b1;
					ctl.wr  = 1'b1;
					wr_addr = '0;
				end else begin
					ctl.rd = (cnt_q != DEPTH_C);
					if (cnt_q != '0) begin
						if (found_q) begin
							ctl.wr  = 1'b1;
							wr_data = carry_q;
						end else if (hit) begin
							ctl.wr = 1'b1;
						end
					end
				end
			end
			ST_RD_REQ: begin
				ctl.rd = 1'b1;
			end
			ST_IDLE, ST_INS_EMIT, ST_RD_OUT: begin
				ctl = '0;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			placed_q <= '0;
			found_q  <= 1'b0;
			count_q  <= '0;
			ovld_q   <= 1'b0;
		end else begin
			if (load) begin
				ovld_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovld_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q    <= '0;
						found_q  <= 1'b0;
						placed_q <= DEPTH_C;
						st_q     <= (s_axis_tuser == CMD_READ) ? ST_RD_REQ : ST_INS_SCAN;
					end
				end
				ST_INS_SCAN: begin
					if (count_q == '0) begin
						found_q  <= 1'b1;
						placed_q <= '0;
						st_q     <= ST_INS_EMIT;
					end else begin
						if ((cnt_q != '0) && !found_q && hit) begin
							found_q  <= 1'b1;
							placed_q <= wslot;
						end
						if (cnt_q == DEPTH_C) begin
							st_q <= ST_INS_EMIT;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_INS_EMIT: begin
					if (out_free) begin
						count_q <= count_nxt;
						st_q    <= ST_IDLE;
					end
				end
				ST_RD_REQ: begin
					st_q <= ST_RD_OUT;
				end
				ST_RD_OUT: begin
					if (out_free) begin
						if (cnt_q == LAST_C) begin
							st_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + CW'(1);
							st_q  <= ST_RD_REQ;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			la_q    <= s_axis_tdata[7:0];
			lb_q    <= s_axis_tdata[15:8];
			lc_q    <= s_axis_tdata[23:16];
			score_q <= s_axis_tdata[39:24];
		end
		// displaced entry rides down one slot per cycle
		if ((st_q == ST_INS_SCAN) && (cnt_q != '0) && (found_q || hit)) begin
			carry_q <= rd_entry;
		end
		if (load) begin
			if (st_q == ST_INS_EMIT) begin
				o_placed_q <= 4'(placed_q);
				o_idx_q    <= '0;
				o_entry_q  <= '0;
				o_count_q  <= 4'(count_nxt);
				o_last_q   <= 1'b1;
			end else begin
				o_placed_q <= '0;
				o_idx_q    <= 3'(cnt_q);
				o_entry_q  <= rd_entry;
				o_count_q  <= 4'(count_q);
				o_last_q   <= (cnt_q == LAST_C);
			end
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {4'b0, o_count_q, o_entry_q.tm, o_entry_q.lc, o_entry_q.lb,
		o_entry_q.la, o_idx_q, o_placed_q};

	`TKST_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH_C)
	`TKST_ASSERT_NXT(a_count_mono, clk, arst_n, 1'b1, count_q >= $past(count_q))
	`TKST_ASSERT_IMP(a_idle_no_write, clk, arst_n, st_q == ST_IDLE, !ctl.wr)
	`TKST_ASSERT_IMP(a_emit_slot, clk, arst_n, (st_q == ST_INS_EMIT) && !found_q,
		placed_q == DEPTH_C)

endmodule

`default_nettype wire

FILE: hdl/tkst_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tkst_store
	import tkst_pkg::*;
#(
	parameter int DEPTH = TKST_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mem_ctl_t                 ctl,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire entry_t                   wr_data,
	output entry_t                        rd_entry
);

	entry_t             mem_q [DEPTH];
	entry_t             rdata_q;
	logic               rvld_q;
	logic [DEPTH-1:0]   vld_q;
	logic [DEPTH-1:0]   vld_nxt;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_comb begin
		vld_nxt = ctl.clr ? '0 : vld_q;
		if (ctl.wr) begin
			vld_nxt[wr_addr] = 1'b1;
		end
	end

	// per-slot valid bits, a slot never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			vld_q <= vld_nxt;
			if (ctl.rd) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_entry = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire
